@@ rtl/vrt_pkg.sv @@
package vrt_pkg;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_MISS  = 2'd2,
        KIND_STRAY = 2'd3
    } kind_t;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [31:0] INF_T = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_START_DONE,
        ST_STEP,
        ST_HIT_MUL,
        ST_HIT_ADD,
        ST_OUT
    } state_t;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

@@ rtl/vrt_div.sv @@
// Restoring divider: one quotient bit per cycle.
module vrt_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrt_pkg::div_ctl_t    ctl,
    input  logic [NUM_W-1:0]     numer,
    input  logic [DEN_W-1:0]     denom,
    output vrt_pkg::div_sts_t    sts,
    output logic [NUM_W-1:0]     quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (ctl.start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = q_reg;
endmodule

@@ rtl/voxel_ray_traversal.sv @@
// Start request: up to six serial divisions, two for each axis whose direction is nonzero,
// plus setup states. Answer request: a step or a miss passes the step state and the output
// state; a hit adds three shared multiplies first. The divider sets the start latency.
// One request at a time; stall is high from acceptance until the result is taken.
// Reset (rst_n, asynchronous, active low) clears all ray state to zero.
module voxel_ray_traversal #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [17:0] dir_x,
    input  logic signed [17:0] dir_y,
    input  logic signed [17:0] dir_z,
    input  logic [30:0]        max_distance,
    input  logic               occupied,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y,
    output logic signed [1:0]  normal_z,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [30:0]        hit_distance
);
    localparam int NUM_W = 2 * FRAC_BITS + 16;
    localparam int DEN_W = 18;
    localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

    vrt_pkg::state_t state_reg, state_next;
    logic            active_reg, active_next;
    logic [1:0]      axis_reg, axis_next;
    logic            which_reg, which_next;

    logic [15:0]        vox_reg   [3];
    logic [31:0]        cross_reg [3];
    logic [31:0]        space_reg [3];
    logic signed [1:0]  sgn_reg   [3];
    logic signed [1:0]  nrm_reg   [3];
    logic signed [31:0] org_reg   [3];
    logic signed [17:0] dir_reg   [3];
    logic [31:0]        walk_reg;
    logic [31:0]        limit_reg;

    logic [1:0]         okind_reg;
    logic signed [31:0] opt_reg [3];
    logic signed [49:0] prod_reg;
    logic               out_valid_reg;
    logic               occ_reg;

    vrt_pkg::div_ctl_t  dctl;
    vrt_pkg::div_sts_t  dsts;
    logic [NUM_W-1:0]   dnum;
    logic [NUM_W-1:0]   quot;
    logic [DEN_W-1:0]   mag;
    logic [FRAC_BITS-1:0] frac;
    logic [NUM_W-1:0]   numv;
    logic [1:0]         side;
    logic [31:0]        csum;
    logic [32:0]        csum_w;
    logic [31:0]        qsat;
    logic signed [49:0] prod_c;
    logic signed [49:0] fl_p;
    logic signed [50:0] psum;
    logic signed [31:0] psat;

    assign mag  = dir_reg[axis_reg][17] ? DEN_W'(-dir_reg[axis_reg])
                                        : DEN_W'(dir_reg[axis_reg]);
    assign frac = org_reg[axis_reg][FRAC_BITS-1:0];
    assign numv = dir_reg[axis_reg][17] ? NUM_W'(frac) : ONE - NUM_W'(frac);
    // The numerator follows the division that is being launched in this cycle.
    assign dnum = which_next ? (ONE << FRAC_BITS) : (numv << FRAC_BITS);
    assign qsat = (quot > NUM_W'(vrt_pkg::INF_T)) ? vrt_pkg::INF_T : quot[31:0];

    vrt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .numer (dnum),
        .denom (mag),
        .sts   (dsts),
        .quot  (quot)
    );

    always_comb
    begin
        if (cross_reg[0] < cross_reg[1])
            side = (cross_reg[0] < cross_reg[2]) ? 2'd0 : 2'd2;
        else
            side = (cross_reg[1] < cross_reg[2]) ? 2'd1 : 2'd2;
    end

    assign csum_w = {1'b0, cross_reg[side]} + {1'b0, space_reg[side]};
    assign csum   = (csum_w > 33'(vrt_pkg::INF_T)) ? vrt_pkg::INF_T : csum_w[31:0];

    // One shared multiplier; the floor shift is an arithmetic shift.
    assign prod_c = 50'(dir_reg[axis_reg]) * $signed({18'd0, walk_reg});
    assign fl_p   = prod_reg >>> FRAC_BITS;
    assign psum   = 51'(org_reg[axis_reg]) + 51'(fl_p);
    assign psat   = (psum > 51'sd2147483647) ? 32'sh7FFF_FFFF :
                    (psum < -51'sd2147483648) ? 32'sh8000_0000 : psum[31:0];

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        axis_next   = axis_reg;
        which_next  = which_reg;
        dctl.start  = 1'b0;
        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == vrt_pkg::OP_START)
                    begin
                        state_next = vrt_pkg::ST_SETUP;
                        axis_next  = 2'd0;
                        which_next = 1'b0;
                    end
                    else
                        state_next = vrt_pkg::ST_STEP;
                end
            end
            vrt_pkg::ST_SETUP:
            begin
                if (axis_reg == 2'd3)
                    state_next = vrt_pkg::ST_START_DONE;
                else if (dir_reg[axis_reg] == '0)
                    axis_next = axis_reg + 2'd1;
                else
                begin
                    dctl.start = 1'b1;
                    state_next = vrt_pkg::ST_DIV;
                end
            end
            vrt_pkg::ST_DIV:
            begin
                if (dsts.done)
                begin
                    which_next = ~which_reg;
                    if (which_reg)
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = vrt_pkg::ST_SETUP;
                    end
                    else
                        dctl.start = 1'b1;
                end
            end
            vrt_pkg::ST_START_DONE:
            begin
                active_next = (limit_reg != '0);
                state_next  = vrt_pkg::ST_OUT;
            end
            vrt_pkg::ST_STEP:
            begin
                axis_next = 2'd0;
                if (!active_reg)
                    state_next = vrt_pkg::ST_OUT;
                else if (occ_reg)
                begin
                    active_next = 1'b0;
                    state_next  = vrt_pkg::ST_HIT_MUL;
                end
                else
                begin
                    if (cross_reg[side] >= limit_reg)
                        active_next = 1'b0;
                    state_next = vrt_pkg::ST_OUT;
                end
            end
            vrt_pkg::ST_HIT_MUL:
                state_next = vrt_pkg::ST_HIT_ADD;
            vrt_pkg::ST_HIT_ADD:
            begin
                axis_next  = axis_reg + 2'd1;
                state_next = (axis_reg == 2'd2) ? vrt_pkg::ST_OUT : vrt_pkg::ST_HIT_MUL;
            end
            vrt_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = vrt_pkg::ST_IDLE;
            end
            default:
                state_next = vrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vrt_pkg::ST_IDLE;
            active_reg <= 1'b0;
            axis_reg   <= '0;
            which_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            axis_reg   <= axis_next;
            which_reg  <= which_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vox_reg[i]   <= '0;
                cross_reg[i] <= '0;
                space_reg[i] <= '0;
                sgn_reg[i]   <= '0;
                nrm_reg[i]   <= '0;
                org_reg[i]   <= '0;
                dir_reg[i]   <= '0;
                opt_reg[i]   <= '0;
            end
            walk_reg  <= '0;
            limit_reg <= '0;
            okind_reg <= '0;
            occ_reg   <= 1'b0;
            prod_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                vrt_pkg::ST_IDLE:
                begin
                    occ_reg <= occupied;
                    for (int i = 0; i < 3; i++)
                        opt_reg[i] <= '0;
                    if (in_valid && op == vrt_pkg::OP_START)
                    begin
                        org_reg[0] <= origin_x;
                        org_reg[1] <= origin_y;
                        org_reg[2] <= origin_z;
                        dir_reg[0] <= dir_x;
                        dir_reg[1] <= dir_y;
                        dir_reg[2] <= dir_z;
                        vox_reg[0] <= 16'(origin_x >>> FRAC_BITS);
                        vox_reg[1] <= 16'(origin_y >>> FRAC_BITS);
                        vox_reg[2] <= 16'(origin_z >>> FRAC_BITS);
                        for (int i = 0; i < 3; i++)
                        begin
                            nrm_reg[i]   <= '0;
                            cross_reg[i] <= vrt_pkg::INF_T;
                            space_reg[i] <= vrt_pkg::INF_T;
                        end
                        sgn_reg[0] <= (dir_x == '0) ? 2'sd0 : (dir_x[17] ? -2'sd1 : 2'sd1);
                        sgn_reg[1] <= (dir_y == '0) ? 2'sd0 : (dir_y[17] ? -2'sd1 : 2'sd1);
                        sgn_reg[2] <= (dir_z == '0) ? 2'sd0 : (dir_z[17] ? -2'sd1 : 2'sd1);
                        limit_reg <= {1'b0, max_distance};
                        walk_reg  <= '0;
                    end
                end
                vrt_pkg::ST_DIV:
                begin
                    if (dsts.done)
                    begin
                        if (which_reg)
                            space_reg[axis_reg] <= (quot == '0) ? 32'd1 : qsat;
                        else
                            cross_reg[axis_reg] <= qsat;
                    end
                end
                vrt_pkg::ST_START_DONE:
                    okind_reg <= (limit_reg != '0) ? vrt_pkg::KIND_QUERY : vrt_pkg::KIND_MISS;
                vrt_pkg::ST_STEP:
                begin
                    if (!active_reg)
                        okind_reg <= vrt_pkg::KIND_STRAY;
                    else if (occ_reg)
                        okind_reg <= vrt_pkg::KIND_HIT;
                    else
                    begin
                        walk_reg <= cross_reg[side];
                        if (cross_reg[side] > limit_reg)
                            okind_reg <= vrt_pkg::KIND_MISS;
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                nrm_reg[i] <= (2'(i) == side) ? -sgn_reg[i] : 2'sd0;
                            vox_reg[side]   <= vox_reg[side] + 16'(sgn_reg[side]);
                            cross_reg[side] <= csum;
                            okind_reg <= (cross_reg[side] < limit_reg) ? vrt_pkg::KIND_QUERY
                                                                       : vrt_pkg::KIND_MISS;
                        end
                    end
                end
                vrt_pkg::ST_HIT_MUL:
                    prod_reg <= prod_c;
                vrt_pkg::ST_HIT_ADD:
                    opt_reg[axis_reg] <= psat;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (state_next == vrt_pkg::ST_OUT);
    end

    logic show_vox;
    logic is_hit;
    assign is_hit   = (okind_reg == vrt_pkg::KIND_HIT);
    assign show_vox = is_hit || (okind_reg == vrt_pkg::KIND_QUERY);

    assign in_stall     = (state_reg != vrt_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = okind_reg;
    assign voxel_x      = show_vox ? vox_reg[0] : '0;
    assign voxel_y      = show_vox ? vox_reg[1] : '0;
    assign voxel_z      = show_vox ? vox_reg[2] : '0;
    assign normal_x     = is_hit ? nrm_reg[0] : '0;
    assign normal_y     = is_hit ? nrm_reg[1] : '0;
    assign normal_z     = is_hit ? nrm_reg[2] : '0;
    assign point_x      = is_hit ? opt_reg[0] : '0;
    assign point_y      = is_hit ? opt_reg[1] : '0;
    assign point_z      = is_hit ? opt_reg[2] : '0;
    assign hit_distance = is_hit ? walk_reg[30:0] : '0;
endmodule
